// ===== rtl/art_pkg.sv =====
// Package: shared types and constants for the address range table.
package art_pkg;
	localparam int ENTRIES = 16;
	localparam int OWNERS = 8;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int POS_W = $clog2(ENTRIES + 2);
	localparam logic [48:0] TOP_ADDR = 49'h1_0000_0000_0000;
	localparam logic [47:0] MAX_ALIGN = 48'h8000_0000_0000;
	localparam logic [48:0] DEF_WS = 49'h0_FFFF_0000_0000;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_ALLOCATE = 2'd1,
		OP_UNREGISTER = 2'd2,
		OP_DECODE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_INVALID = 3'd1,
		ST_NOFIT = 3'd2,
		ST_ADDR_ERR = 3'd3,
		ST_TYPE_ERR = 3'd4,
		ST_FULL = 3'd5
	} status_t;

	typedef enum logic {
		REG_WIN_START = 1'b0,
		REG_WIN_END = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] owner;
		logic [48:0] start_addr;
		logic [48:0] end_addr;
		logic use_default_window;
		logic [48:0] alloc_size;
		logic [47:0] alignment;
		logic [3:0] handler_mask;
		logic [47:0] access_address;
		logic [15:0] access_length;
		logic [1:0] access_kind;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [48:0] result_address;
		logic [2:0] target_owner;
	} rsp_t;
endpackage

// ===== rtl/art_if.sv =====
// Interface: valid/ready channel carrying one payload.
interface art_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/address_range_table_top.sv =====
// Top level: address range table with sequential walk and shift engine.
// The walk and the shifter both move one entry per cycle; one request at a time.
// The result waits in an output register; the next request is taken only after it is accepted.
// Reset: asynchronous, clears count, state and result, loads the default window;
// table contents are undefined until written.
module address_range_table_top (
	input logic clk,
	input logic arst_n,
	art_if.sink req,
	art_if.source rsp,
	input logic cfg_we,
	input logic cfg_index,
	input logic [48:0] cfg_wdata
);
	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_WALK, S_SHIFT, S_WRITE, S_DONE} state_t;

	state_t state_q;
	art_pkg::req_t r_q;
	logic [48:0] ws_q, we_q, dws_q, dwe_q;
	logic [63:0] mask_q;
	logic [art_pkg::CNT_W-1:0] count_q;
	logic [art_pkg::POS_W-1:0] v_q, k_q;
	logic [48:0] ns_q, ne_q;
	logic [1:0] mode_q;
	logic rem_q;
	logic [2:0] status_q, tgt_q;
	logic [48:0] addr_q;
	logic rvalid_q;

	logic [48:0] mem_start [art_pkg::ENTRIES];
	logic [48:0] mem_end [art_pkg::ENTRIES];
	logic [2:0] mem_owner [art_pkg::ENTRIES];
	logic [3:0] mem_hand [art_pkg::ENTRIES];

	// walk position helpers
	logic [48:0] cur_end, nxt_start, e_start, e_end;
	logic [2:0] e_owner;
	logic [3:0] e_hand;
	logic [art_pkg::IDX_W-1:0] vi, vm1;
	logic [63:0] al64, a1ea, a2sa, ws64, size64, d1, d2, ns64;
	logic [art_pkg::POS_W-1:0] cnt_ext;

	assign cnt_ext = art_pkg::POS_W'(count_q);
	assign vi = v_q[art_pkg::IDX_W-1:0];
	assign vm1 = art_pkg::IDX_W'(v_q - 1'b1);
	assign e_start = mem_start[vi];
	assign e_end = mem_end[vi];
	assign e_owner = mem_owner[vi];
	assign e_hand = mem_hand[vi];

	always_comb begin
		if (v_q == '0) cur_end = '0;
		else if (v_q > cnt_ext) cur_end = art_pkg::TOP_ADDR;
		else cur_end = mem_end[vm1];
		if (v_q >= cnt_ext) nxt_start = art_pkg::TOP_ADDR;
		else nxt_start = mem_start[vi];
	end

	assign al64 = {16'd0, r_q.alignment};
	assign a1ea = ({15'd0, cur_end} + al64 - 64'd1) & mask_q;
	assign a2sa = {15'd0, nxt_start} & mask_q;
	assign ws64 = {15'd0, ws_q};
	assign size64 = {15'd0, r_q.alloc_size};
	assign d1 = a2sa - a1ea;
	assign d2 = a2sa - ws64;
	assign ns64 = (ws64 > a1ea) ? ws64 : a1ea;

	logic al_bad, win_bad, reg_bad;
	assign al_bad = (r_q.alignment[1:0] != 2'b00) || (r_q.alignment > art_pkg::MAX_ALIGN)
		|| (r_q.alignment == '0) || ((r_q.alignment & (r_q.alignment - 48'd1)) != '0);
	assign win_bad = (({15'd0, ws_q | we_q} & ~mask_q) != '0) || (ws_q >= we_q)
		|| (we_q > art_pkg::TOP_ADDR);
	assign reg_bad = ((r_q.start_addr[1:0] | r_q.end_addr[1:0]) != 2'b00)
		|| (r_q.start_addr >= r_q.end_addr) || (r_q.end_addr > art_pkg::TOP_ADDR);

	logic full, owner_bad;
	assign full = (count_q >= art_pkg::CNT_W'(art_pkg::ENTRIES));
	assign owner_bad = ({29'd0, r_q.owner} >= 32'(art_pkg::OWNERS));

	assign req.ready = (state_q == S_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data.status = status_q;
	assign rsp.data.result_address = addr_q;
	assign rsp.data.target_owner = tgt_q;

	always_ff @(posedge clk) begin
		if (state_q == S_SHIFT) begin
			if (!rem_q && k_q > v_q) begin
				mem_start[k_q[art_pkg::IDX_W-1:0]] <= mem_start[art_pkg::IDX_W'(k_q - 1'b1)];
				mem_end[k_q[art_pkg::IDX_W-1:0]] <= mem_end[art_pkg::IDX_W'(k_q - 1'b1)];
				mem_owner[k_q[art_pkg::IDX_W-1:0]] <= mem_owner[art_pkg::IDX_W'(k_q - 1'b1)];
				mem_hand[k_q[art_pkg::IDX_W-1:0]] <= mem_hand[art_pkg::IDX_W'(k_q - 1'b1)];
			end else if (rem_q && (k_q + 1'b1) < cnt_ext) begin
				mem_start[k_q[art_pkg::IDX_W-1:0]] <= mem_start[art_pkg::IDX_W'(k_q + 1'b1)];
				mem_end[k_q[art_pkg::IDX_W-1:0]] <= mem_end[art_pkg::IDX_W'(k_q + 1'b1)];
				mem_owner[k_q[art_pkg::IDX_W-1:0]] <= mem_owner[art_pkg::IDX_W'(k_q + 1'b1)];
				mem_hand[k_q[art_pkg::IDX_W-1:0]] <= mem_hand[art_pkg::IDX_W'(k_q + 1'b1)];
			end
		end else if (state_q == S_WRITE) begin
			mem_start[vi] <= ns_q;
			mem_end[vi] <= ne_q;
			mem_owner[vi] <= r_q.owner;
			mem_hand[vi] <= r_q.handler_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rvalid_q <= 1'b0;
			dws_q <= art_pkg::DEF_WS;
			dwe_q <= art_pkg::TOP_ADDR;
			status_q <= '0;
			addr_q <= '0;
			tgt_q <= '0;
			v_q <= '0;
			k_q <= '0;
			rem_q <= 1'b0;
			mode_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == art_pkg::REG_WIN_START) dws_q <= cfg_wdata;
				else dwe_q <= cfg_wdata;
			end
			if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q <= req.data;
						mode_q <= req.data.op;
						ws_q <= req.data.use_default_window ? dws_q : req.data.start_addr;
						we_q <= req.data.use_default_window ? dwe_q : req.data.end_addr;
						mask_q <= ~({16'd0, req.data.alignment} - 64'd1);
						v_q <= '0;
						addr_q <= '0;
						tgt_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if ((mode_q == art_pkg::OP_REGISTER && (owner_bad || reg_bad))
						|| (mode_q == art_pkg::OP_ALLOCATE && (owner_bad || al_bad || win_bad))
						|| (mode_q == art_pkg::OP_UNREGISTER && owner_bad)) begin
						status_q <= art_pkg::ST_INVALID; state_q <= S_DONE;
					end else if ((mode_q == art_pkg::OP_REGISTER
						|| mode_q == art_pkg::OP_ALLOCATE) && full) begin
						status_q <= art_pkg::ST_FULL; state_q <= S_DONE;
					end else state_q <= S_WALK;
				end
				S_WALK: begin
					case (mode_q)
						art_pkg::OP_REGISTER: begin
							if (cur_end > r_q.start_addr) begin
								status_q <= art_pkg::ST_NOFIT; state_q <= S_DONE;
							end else if (nxt_start >= r_q.end_addr) begin
								ns_q <= r_q.start_addr; ne_q <= r_q.end_addr;
								rem_q <= 1'b0; k_q <= cnt_ext; state_q <= S_SHIFT;
							end else if (v_q > cnt_ext) begin
								status_q <= art_pkg::ST_NOFIT; state_q <= S_DONE;
							end else v_q <= v_q + 1'b1;
						end
						art_pkg::OP_ALLOCATE: begin
							if (v_q > cnt_ext) begin
								status_q <= art_pkg::ST_NOFIT; state_q <= S_DONE;
							end else if (d1 >= size64 && d2 >= size64 && a2sa > ws64) begin
								ns_q <= ns64[48:0];
								ne_q <= 49'(ns64 + size64);
								addr_q <= ns64[48:0];
								rem_q <= 1'b0; k_q <= cnt_ext; state_q <= S_SHIFT;
							end else v_q <= v_q + 1'b1;
						end
						art_pkg::OP_UNREGISTER: begin
							if (v_q >= cnt_ext) begin
								status_q <= art_pkg::ST_NOFIT; state_q <= S_DONE;
							end else if (e_owner == r_q.owner && e_start == r_q.start_addr) begin
								rem_q <= 1'b1; k_q <= v_q; state_q <= S_SHIFT;
							end else v_q <= v_q + 1'b1;
						end
						default: begin
							if (v_q >= cnt_ext || e_start > {1'b0, r_q.access_address}) begin
								status_q <= art_pkg::ST_ADDR_ERR; state_q <= S_DONE;
							end else if (e_end > {1'b0, r_q.access_address}) begin
								state_q <= S_DONE;
								if (!r_q.access_kind[1] && (e_end - {1'b0, r_q.access_address})
									< {33'd0, r_q.access_length})
									status_q <= art_pkg::ST_ADDR_ERR;
								else if (!e_hand[r_q.access_kind])
									status_q <= art_pkg::ST_TYPE_ERR;
								else begin
									status_q <= art_pkg::ST_OK; tgt_q <= e_owner;
								end
							end else v_q <= v_q + 1'b1;
						end
					endcase
				end
				S_SHIFT: begin
					if (!rem_q) begin
						if (k_q > v_q) k_q <= k_q - 1'b1;
						else state_q <= S_WRITE;
					end else begin
						if ((k_q + 1'b1) < cnt_ext) k_q <= k_q + 1'b1;
						else begin
							count_q <= count_q - 1'b1;
							status_q <= art_pkg::ST_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					count_q <= count_q + 1'b1;
					status_q <= art_pkg::ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					rvalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= art_pkg::CNT_W'(art_pkg::ENTRIES))
		else $error("range count above table size");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> !req.ready)
		else $error("request taken while result pending");
	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow count");
endmodule

// ===== verif/tb_address_range_table_top.sv =====
// Testbench: address range table, self-checking against an in-bench table predictor.
module tb_address_range_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import art_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int DRAIN = 2 * ENTRIES + 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [48:0] cfg_wdata;

	art_if #(.T(req_t)) req_ch ();
	art_if #(.T(rsp_t)) rsp_ch ();

	address_range_table_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [48:0] tbl_start [ENTRIES];
	logic [48:0] tbl_end [ENTRIES];
	logic [2:0] tbl_owner [ENTRIES];
	logic [3:0] tbl_handlers [ENTRIES];
	int tbl_count;
	logic [48:0] win_start;
	logic [48:0] win_end;

	rsp_t pending_results[$];
	int mismatches;
	int cycles;
	bit req_idle_on;
	bit rsp_idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] walk_start(int v);
		if (v == 0) return 64'd0;
		if (v > tbl_count) return 64'(TOP_ADDR);
		return 64'(tbl_start[v - 1]);
	endfunction

	function automatic logic [63:0] walk_end(int v);
		if (v == 0) return 64'd0;
		if (v > tbl_count) return 64'(TOP_ADDR);
		return 64'(tbl_end[v - 1]);
	endfunction

	function automatic void insert_range(int pos, logic [63:0] s, logic [63:0] e,
			logic [2:0] own, logic [3:0] hm);
		for (int i = tbl_count; i > pos; i--) begin
			tbl_start[i] = tbl_start[i - 1];
			tbl_end[i] = tbl_end[i - 1];
			tbl_owner[i] = tbl_owner[i - 1];
			tbl_handlers[i] = tbl_handlers[i - 1];
		end
		tbl_start[pos] = s[48:0];
		tbl_end[pos] = e[48:0];
		tbl_owner[pos] = own;
		tbl_handlers[pos] = hm;
		tbl_count++;
	endfunction

	function automatic rsp_t predict_table_op(req_t r);
		rsp_t o;
		logic [63:0] s, e, sz, al, msk, a1ea, a2sa, ns, a;
		bit done;
		o = '0;
		done = 0;
		case (op_t'(r.op))
			OP_REGISTER: begin
				s = 64'(r.start_addr);
				e = 64'(r.end_addr);
				if (((s | e) & 64'd3) != 0 || s >= e || e > 64'(TOP_ADDR)) begin
					o.status = ST_INVALID;
				end else if (tbl_count >= ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					o.status = ST_NOFIT;
					for (int v = 0; v <= tbl_count + 1; v++) begin
						if (!done) begin
							if (walk_end(v) > s) begin
								done = 1;
							end else if (v <= tbl_count && walk_start(v + 1) >= e) begin
								insert_range(v, s, e, r.owner, r.handler_mask);
								o.status = ST_OK;
								done = 1;
							end
						end
					end
				end
			end
			OP_ALLOCATE: begin
				s = r.use_default_window ? 64'(win_start) : 64'(r.start_addr);
				e = r.use_default_window ? 64'(win_end) : 64'(r.end_addr);
				sz = 64'(r.alloc_size);
				al = 64'(r.alignment);
				msk = ~(al - 64'd1);
				if ((al & 64'd3) != 0 || al > 64'(MAX_ALIGN) || al == 0
						|| (al & (al - 64'd1)) != 0) begin
					o.status = ST_INVALID;
				end else if (((s | e) & ~msk) != 0 || s >= e || e > 64'(TOP_ADDR)) begin
					o.status = ST_INVALID;
				end else if (tbl_count >= ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					o.status = ST_NOFIT;
					for (int v = 0; v <= tbl_count; v++) begin
						if (!done) begin
							a1ea = (walk_end(v) + al - 64'd1) & msk;
							a2sa = walk_start(v + 1) & msk;
							if ((a2sa - a1ea >= sz) && (a2sa - s >= sz) && (a2sa > s)) begin
								ns = (s > a1ea) ? s : a1ea;
								insert_range(v, ns, ns + sz, r.owner, r.handler_mask);
								o.status = ST_OK;
								o.result_address = ns[48:0];
								done = 1;
							end
						end
					end
				end
			end
			OP_UNREGISTER: begin
				o.status = ST_NOFIT;
				for (int i = 0; i < tbl_count; i++) begin
					if (!done && tbl_owner[i] == r.owner && tbl_start[i] == r.start_addr) begin
						for (int j = i; j + 1 < tbl_count; j++) begin
							tbl_start[j] = tbl_start[j + 1];
							tbl_end[j] = tbl_end[j + 1];
							tbl_owner[j] = tbl_owner[j + 1];
							tbl_handlers[j] = tbl_handlers[j + 1];
						end
						tbl_count--;
						o.status = ST_OK;
						done = 1;
					end
				end
			end
			default: begin
				a = 64'(r.access_address);
				o.status = ST_ADDR_ERR;
				for (int i = 0; i < tbl_count; i++) begin
					if (!done) begin
						if (64'(tbl_start[i]) > a) begin
							done = 1;
						end else if (64'(tbl_end[i]) > a) begin
							done = 1;
							if (r.access_kind < 2 && 64'(tbl_end[i]) - a < 64'(r.access_length))
								o.status = ST_ADDR_ERR;
							else if (!tbl_handlers[i][r.access_kind])
								o.status = ST_TYPE_ERR;
							else begin
								o.status = ST_OK;
								o.target_owner = tbl_owner[i];
							end
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	// result checker
	initial begin
		rsp_t exp_rsp;
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rsp_idle_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", rsp_ch.data);
			end else begin
				exp_rsp = pending_results.pop_front();
				if (rsp_ch.data.status !== exp_rsp.status
						|| rsp_ch.data.result_address !== exp_rsp.result_address
						|| rsp_ch.data.target_owner !== exp_rsp.target_owner) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp status %0d addr %h owner %0d, got %0d %h %0d",
							exp_rsp.status, exp_rsp.result_address, exp_rsp.target_owner,
							rsp_ch.data.status, rsp_ch.data.result_address,
							rsp_ch.data.target_owner);
				end
			end
		end
	end

	task automatic send_request(req_t r);
		int gap;
		gap = req_idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_table_op(r));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_window(logic [48:0] ws, logic [48:0] we);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_WIN_START;
		cfg_wdata <= ws;
		@(posedge clk);
		cfg_index <= REG_WIN_END;
		cfg_wdata <= we;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_start = ws;
		win_end = we;
	endtask

	function automatic req_t mk(op_t op, logic [2:0] own, logic [48:0] s, logic [48:0] e);
		req_t r;
		r = '0;
		r.op = op;
		r.owner = own;
		r.start_addr = s;
		r.end_addr = e;
		r.handler_mask = 4'hf;
		return r;
	endfunction

	function automatic req_t mk_alloc(logic use_def, logic [48:0] s, logic [48:0] e,
			logic [48:0] sz, logic [47:0] al);
		req_t r;
		r = mk(OP_ALLOCATE, 3'($urandom_range(0, 7)), s, e);
		r.use_default_window = use_def;
		r.alloc_size = sz;
		r.alignment = al;
		r.handler_mask = 4'($urandom_range(0, 15));
		return r;
	endfunction

	function automatic req_t mk_decode(logic [47:0] a, logic [15:0] len, logic [1:0] kind);
		req_t r;
		r = mk(OP_DECODE, 0, 0, 0);
		r.access_address = a;
		r.access_length = len;
		r.access_kind = kind;
		return r;
	endfunction

	function automatic logic [48:0] pick_addr();
		logic [48:0] base;
		case ($urandom_range(0, 9))
			0: return 49'({$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFC);
			1: return TOP_ADDR;
			2: return 49'({$urandom, $urandom});
			default: begin
				case ($urandom_range(0, 3))
					0: base = 49'd0;
					1: base = DEF_WS;
					2: base = 49'h0_8000_0000_0000;
					default: base = TOP_ADDR - 49'h400;
				endcase
				return base + 49'($urandom_range(0, 255) * 4);
			end
		endcase
	endfunction

	function automatic logic [47:0] pick_align();
		if ($urandom_range(0, 9) == 0) return 48'({$urandom, $urandom});
		if ($urandom_range(0, 1)) return 48'd1 << $urandom_range(2, 10);
		return 48'd1 << $urandom_range(2, 47);
	endfunction

	function automatic req_t random_request();
		req_t r;
		logic [287:0] raw;
		logic [48:0] s;
		logic [47:0] al;
		int i;
		int sel;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		sel = $urandom_range(0, 99);
		if (tbl_count >= ENTRIES - 2 && sel < 60) sel = sel + 40;
		if (sel < 28) begin
			s = pick_addr();
			r.op = OP_REGISTER;
			r.start_addr = s;
			r.end_addr = ($urandom_range(0, 7) == 0) ? pick_addr()
				: s + 49'($urandom_range(1, 64) * 4);
		end else if (sel < 48) begin
			r.op = OP_ALLOCATE;
			al = pick_align();
			r.alignment = al;
			r.use_default_window = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 7) != 0) begin
				r.start_addr = pick_addr() & ~49'(al - 48'd1);
				r.end_addr = $urandom_range(0, 1) ? TOP_ADDR
					: r.start_addr + (49'(al) << $urandom_range(0, 4));
			end
			if ($urandom_range(0, 7) != 0) r.alloc_size = 49'($urandom_range(0, 4096));
		end else if (sel < 68) begin
			r.op = OP_UNREGISTER;
			if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
				i = $urandom_range(0, tbl_count - 1);
				r.start_addr = tbl_start[i];
				if ($urandom_range(0, 4) != 0) r.owner = tbl_owner[i];
			end
		end else begin
			r.op = OP_DECODE;
			if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
				i = $urandom_range(0, tbl_count - 1);
				if ($urandom_range(0, 1))
					r.access_address = 48'(tbl_start[i] + 49'($urandom_range(0, 16)));
				else
					r.access_address = 48'(tbl_end[i] - 49'($urandom_range(1, 16)));
				r.access_address = 48'(r.access_address - 48'($urandom_range(0, 1) * 8));
				if ($urandom_range(0, 3) != 0) r.access_length = 16'($urandom_range(0, 40));
			end
		end
		return r;
	endfunction

	task automatic test_register_decode();
		req_t r;
		send_request(mk(OP_REGISTER, 0, 0, 4));
		r = mk(OP_REGISTER, 7, TOP_ADDR - 4, TOP_ADDR);
		r.handler_mask = 4'h1;
		send_request(r);
		send_request(mk(OP_REGISTER, 1, 4, 4));
		send_request(mk(OP_REGISTER, 1, 5, 8));
		send_request(mk(OP_REGISTER, 1, 8, 10));
		send_request(mk(OP_REGISTER, 1, 8, TOP_ADDR + 4));
		send_request(mk(OP_REGISTER, 1, 0, 8));
		send_request(mk_decode(0, 4, 0));
		send_request(mk_decode(0, 5, 1));
		send_request(mk_decode(0, 16'hffff, 2));
		send_request(mk_decode(100, 0, 3));
		send_request(mk_decode(48'hFFFF_FFFF_FFFC, 0, 1));
		send_request(mk_decode(48'hFFFF_FFFF_FFFF, 4, 0));
		send_request(mk_decode(48'hFFFF_FFFF_FFFF, 0, 0));
		send_request(mk_decode(48'hFFFF_FFFF_FFFF, 0, 3));
	endtask

	task automatic test_allocate();
		send_request(mk_alloc(0, 0, TOP_ADDR, 16, 48'd2));
		send_request(mk_alloc(0, 0, TOP_ADDR, 16, 48'd12));
		send_request(mk_alloc(0, 0, TOP_ADDR, 16, 48'hFFFF_FFFF_FFFF));
		send_request(mk_alloc(0, 0, TOP_ADDR, 16, MAX_ALIGN));
		send_request(mk_alloc(0, 6, TOP_ADDR, 16, 48'd8));
		send_request(mk_alloc(1, 0, 0, 49'h1000, 48'h1000));
		send_request(mk_alloc(0, 49'h100, 49'h200, 0, 48'd4));
		send_request(mk_alloc(0, 49'h100, 49'h200, 49'h1_FFFF_FFFF_FFFF, 48'd4));
	endtask

	task automatic test_unregister();
		send_request(mk(OP_UNREGISTER, 0, 0, 0));
		send_request(mk(OP_UNREGISTER, 0, 0, 0));
		send_request(mk(OP_UNREGISTER, 3, TOP_ADDR - 4, 0));
		while (tbl_count > 0)
			send_request(mk(OP_UNREGISTER, tbl_owner[0], tbl_start[0], 0));
	endtask

	task automatic test_table_full();
		for (int i = 0; i < ENTRIES; i++)
			send_request(mk(OP_REGISTER, 3'(i), 49'(i * 64), 49'(i * 64 + 32)));
		send_request(mk(OP_REGISTER, 0, 49'h1000, 49'h1004));
		send_request(mk_alloc(1, 0, 0, 4, 48'd4));
		send_request(mk(OP_REGISTER, 0, 49'h1000, 49'h1002));
		while (tbl_count > 0)
			send_request(mk(OP_UNREGISTER, tbl_owner[0], tbl_start[0], 0));
	endtask

	task automatic test_window_config();
		write_window(0, TOP_ADDR);
		send_request(mk_alloc(1, 0, 0, 8, 48'd4));
		write_window(TOP_ADDR, TOP_ADDR);
		send_request(mk_alloc(1, 0, 0, 8, 48'd4));
		write_window(49'h1_FFFF_FFFF_FFFF, 49'h0_0000_0000_0004);
		send_request(mk_alloc(1, 0, 0, 8, 48'd4));
		write_window(49'h0_0000_0001_0002, 49'h0_0000_0002_0000);
		send_request(mk_alloc(1, 0, 0, 8, 48'd4));
		send_request(mk(OP_UNREGISTER, tbl_owner[0], tbl_start[0], 0));
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			req_idle_on = (phase != 1);
			rsp_idle_on = (phase != 2);
			for (int n = 0; n < 425; n++)
				send_request(random_request());
			write_window(pick_addr() & 49'h1_FFFF_FFFF_F000,
				$urandom_range(0, 1) ? TOP_ADDR : pick_addr());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIN_START;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cycles = 0;
		mismatches = 0;
		tbl_count = 0;
		win_start = DEF_WS;
		win_end = TOP_ADDR;
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_decode();
		test_allocate();
		test_unregister();
		test_table_full();
		test_window_config();
		test_random();
		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
